// ----- rtl/frequency_duty_meter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frequency and duty meter
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_DUTY_METER_ASSERT_SVH
`define FREQUENCY_DUTY_METER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frequency_duty_meter: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define FDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frequency_duty_meter: assertion failed");

`endif

// ----- rtl/fdm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdm_pkg
// Widths, reset values, register indexes and helpers of the meter.
// ----------------------------------------------------------------------------
package fdm_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int GATE_W      = 10;
  localparam int FREQ_W      = 18;
  localparam int TOTAL_W     = 17;
  localparam int DUTY_W      = 14;
  localparam int THR_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = FREQ_W + DUTY_W;
  localparam int NUM_W       = TOTAL_W + DUTY_W;
  localparam int SAT_W       = (COUNT_WIDTH + 2 > FREQ_W) ? COUNT_WIDTH + 2 : FREQ_W;
  localparam int STEP_W      = $clog2(DUTY_W);

  localparam logic [FREQ_W-1:0]  FREQ_MAX    = {FREQ_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [DUTY_W-1:0]  DUTY_SCALE  = DUTY_W'(10000);

  localparam logic [GATE_W-1:0]  SHORT_GATE_RST = GATE_W'(247);
  localparam logic [GATE_W-1:0]  LONG_GATE_RST  = GATE_W'(985);
  localparam logic [THR_W-1:0]   FAST_HIGH_RST  = THR_W'(50);
  localparam logic [TOTAL_W-1:0] DUTY_MIN_RST   = TOTAL_W'(20000);
  localparam logic [TOTAL_W-1:0] DUTY_MAX_RST   = TOTAL_W'(80000);
  localparam logic [FREQ_W-1:0]  FAST_FREQ_RST  = FREQ_W'(10000);
  localparam logic [FREQ_W-1:0]  LAST_FREQ_RST  = FREQ_W'(121212);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_SHORT_GATE = 3'd1,
    REG_LONG_GATE  = 3'd2,
    REG_FAST_HIGH  = 3'd3,
    REG_DUTY_MIN   = 3'd4,
    REG_DUTY_MAX   = 3'd5,
    REG_FAST_FREQ  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    KIND_FREQ = 1'b0,
    KIND_DUTY = 1'b1
  } result_kind_t;

  // Divider handshake: start with operands, done with quotient held.
  typedef struct packed {
    logic                start;
    logic [TOTAL_W-1:0]  high;
    logic [TOTAL_W-1:0]  total;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DUTY_W-1:0]   quotient;
  } div_rsp_t;

  function automatic logic [FREQ_W-1:0] sat_freq(input logic [SAT_W-1:0] v);
    if (v > SAT_W'(FREQ_MAX)) begin
      return FREQ_MAX;
    end
    return v[FREQ_W-1:0];
  endfunction

endpackage

// ----- rtl/frequency_duty_meter.sv -----
// ----------------------------------------------------------------------------
// frequency_duty_meter
// Gated frequency counter with a duty-cycle sampler on one digital input.
// ----------------------------------------------------------------------------
// Each input word carries one time step: a millisecond tick, a pulse edge, a
// duty sample strobe and the sampled level. In frequency mode pulses advance a
// wrapping 16-bit counter and ticks a 10-bit gate counter; at the short gate a
// fast count (high byte above fast_high) reports four times the count,
// otherwise the long gate reports the count itself, saturated to 18 bits, and
// both counters restart at once. In duty mode samples are accumulated until
// the window thresholds are met, then 10000*high/total is reported in
// hundredths of percent and the totals clear. A word that closes a duty window
// holds the input while the divider runs (scaling multiply, 14 restoring
// steps, result hand-off) and while the hand-off waits on a full output
// register. The output register lets a word be taken while no result waits
// or the waiting one is being drained. Configuration is to be written by the
// user only while idle; the block does not enforce it. Changing the mode
// clears the totals (entering duty) or the pulse count (entering frequency).
// ----------------------------------------------------------------------------
module frequency_duty_meter
  import fdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ms_tick, pulse, sample_strobe, level, zero fill
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // frequency_hz[17:0], duty_hundredths[31:18]
  output logic                  out_tuser,  // result_kind
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "frequency_duty_meter_assert.svh"

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t               state_r, state_nxt;

  // configuration registers
  logic                 mode_r, mode_nxt;
  logic [GATE_W-1:0]    short_gate_r, short_gate_nxt;
  logic [GATE_W-1:0]    long_gate_r, long_gate_nxt;
  logic [THR_W-1:0]     fast_high_r, fast_high_nxt;
  logic [TOTAL_W-1:0]   duty_min_r, duty_min_nxt;
  logic [TOTAL_W-1:0]   duty_max_r, duty_max_nxt;
  logic [FREQ_W-1:0]    fast_freq_r, fast_freq_nxt;

  // measurement state
  logic [GATE_W-1:0]      gate_cnt_r, gate_cnt_nxt;
  logic [COUNT_WIDTH-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [FREQ_W-1:0]      last_freq_r, last_freq_nxt;
  logic [TOTAL_W-1:0]     sample_total_r, sample_total_nxt;
  logic [TOTAL_W-1:0]     high_total_r, high_total_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [FREQ_W-1:0]    out_freq_r, out_freq_nxt;
  logic [DUTY_W-1:0]    out_duty_r, out_duty_nxt;

  logic                   in_acc;
  logic                   ms_tick, pulse, sample_strobe, level;
  logic                   out_free;
  logic [COUNT_WIDTH-1:0] pulse_inc;
  logic [GATE_W-1:0]      gate_inc;
  logic                   short_hit, long_hit;
  logic [FREQ_W-1:0]      freq_val;
  logic [TOTAL_W-1:0]     total_inc, high_inc;
  logic                   duty_hit;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign ms_tick       = in_tdata[0];
  assign pulse         = in_tdata[1];
  assign sample_strobe = in_tdata[2];
  assign level         = in_tdata[3];

  // The output register is free when empty or drained this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Frequency path: count the pulse first so it belongs to a closing window.
  assign pulse_inc = pulse_cnt_r + COUNT_WIDTH'(pulse);
  assign gate_inc  = gate_cnt_r + GATE_W'(1);
  assign short_hit = ms_tick && (gate_inc == short_gate_r) &&
                     ((pulse_inc >> 8) > COUNT_WIDTH'(fast_high_r));
  assign long_hit  = ms_tick && !short_hit && (gate_inc == long_gate_r);
  assign freq_val  = short_hit ? sat_freq(SAT_W'(pulse_inc) << 2)
                               : sat_freq(SAT_W'(pulse_inc));

  // Duty path: saturating totals, window test on the updated total.
  assign total_inc = (sample_strobe && sample_total_r != TOTAL_MAX) ?
                     sample_total_r + TOTAL_W'(1) : sample_total_r;
  assign high_inc  = (sample_strobe && level && high_total_r != TOTAL_MAX) ?
                     high_total_r + TOTAL_W'(1) : high_total_r;
  assign duty_hit  = ((total_inc > duty_min_r) && (last_freq_r > fast_freq_r)) ||
                     (total_inc > duty_max_r);

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    short_gate_nxt   = short_gate_r;
    long_gate_nxt    = long_gate_r;
    fast_high_nxt    = fast_high_r;
    duty_min_nxt     = duty_min_r;
    duty_max_nxt     = duty_max_r;
    fast_freq_nxt    = fast_freq_r;
    gate_cnt_nxt     = gate_cnt_r;
    pulse_cnt_nxt    = pulse_cnt_r;
    last_freq_nxt    = last_freq_r;
    sample_total_nxt = sample_total_r;
    high_total_nxt   = high_total_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_kind_nxt     = out_kind_r;
    out_freq_nxt     = out_freq_r;
    out_duty_nxt     = out_duty_r;
    div_req.start    = 1'b0;
    div_req.high     = high_inc;
    div_req.total    = total_inc;

    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE: begin
          if (cfg_wdata[0] != mode_r) begin
            if (cfg_wdata[0]) begin
              sample_total_nxt = '0;
              high_total_nxt   = '0;
            end else begin
              pulse_cnt_nxt = '0;
            end
          end
          mode_nxt = cfg_wdata[0];
        end
        REG_SHORT_GATE: short_gate_nxt = cfg_wdata[GATE_W-1:0];
        REG_LONG_GATE:  long_gate_nxt  = cfg_wdata[GATE_W-1:0];
        REG_FAST_HIGH:  fast_high_nxt  = cfg_wdata[THR_W-1:0];
        REG_DUTY_MIN:   duty_min_nxt   = cfg_wdata[TOTAL_W-1:0];
        REG_DUTY_MAX:   duty_max_nxt   = cfg_wdata[TOTAL_W-1:0];
        REG_FAST_FREQ:  fast_freq_nxt  = cfg_wdata[FREQ_W-1:0];
        default: ;
      endcase
    end

    if (in_acc) begin
      if (!mode_r) begin
        pulse_cnt_nxt = pulse_inc;
        if (ms_tick) begin
          gate_cnt_nxt = gate_inc;
        end
        if (short_hit || long_hit) begin
          // close the gate, restart counting at once
          gate_cnt_nxt  = '0;
          pulse_cnt_nxt = '0;
          last_freq_nxt = freq_val;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FREQ;
          out_freq_nxt  = freq_val;
          out_duty_nxt  = '0;
        end
      end else begin
        sample_total_nxt = total_inc;
        high_total_nxt   = high_inc;
        if (duty_hit) begin
          // hand the window to the divider and hold the input
          sample_total_nxt = '0;
          high_total_nxt   = '0;
          div_req.start    = 1'b1;
          state_nxt        = S_DIV;
        end
      end
    end

    if (state_r == S_DIV && div_rsp.done && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_DUTY;
      out_freq_nxt  = '0;
      out_duty_nxt  = div_rsp.quotient;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_r         <= 1'b0;
      short_gate_r   <= SHORT_GATE_RST;
      long_gate_r    <= LONG_GATE_RST;
      fast_high_r    <= FAST_HIGH_RST;
      duty_min_r     <= DUTY_MIN_RST;
      duty_max_r     <= DUTY_MAX_RST;
      fast_freq_r    <= FAST_FREQ_RST;
      gate_cnt_r     <= '0;
      pulse_cnt_r    <= '0;
      last_freq_r    <= LAST_FREQ_RST;
      sample_total_r <= '0;
      high_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      mode_r         <= mode_nxt;
      short_gate_r   <= short_gate_nxt;
      long_gate_r    <= long_gate_nxt;
      fast_high_r    <= fast_high_nxt;
      duty_min_r     <= duty_min_nxt;
      duty_max_r     <= duty_max_nxt;
      fast_freq_r    <= fast_freq_nxt;
      gate_cnt_r     <= gate_cnt_nxt;
      pulse_cnt_r    <= pulse_cnt_nxt;
      last_freq_r    <= last_freq_nxt;
      sample_total_r <= sample_total_nxt;
      high_total_r   <= high_total_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_freq_r <= out_freq_nxt;
    out_duty_r <= out_duty_nxt;
  end

  fdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_duty_r, out_freq_r};

  // high samples are a subset of all samples
  `FDM_ASSERT_IMP(a_high_le_total, 1'b1, high_total_r <= sample_total_r)
  // a duty result never exceeds 100.00 percent
  `FDM_ASSERT_IMP(a_duty_range, out_valid_r && out_kind_r == KIND_DUTY,
                  out_duty_r <= DUTY_SCALE)
  // a closing duty window starts the divider and clears the totals
  `FDM_ASSERT_NEXT(a_duty_start, in_acc && mode_r && duty_hit,
                   state_r == S_DIV && sample_total_r == '0 && !div_rsp.done)
  // a frequency result sets the kept frequency and restarts the gate
  `FDM_ASSERT_NEXT(a_freq_close, in_acc && !mode_r && (short_hit || long_hit),
                   out_valid_r && last_freq_r == out_freq_r && gate_cnt_r == '0)

endmodule

// ----- rtl/fdm_div.sv -----
// ----------------------------------------------------------------------------
// fdm_div
// Duty ratio unit: scales the high count by 10000, then divides by the
// sample total with one restoring step per cycle.
// ----------------------------------------------------------------------------
module fdm_div
  import fdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_STEP,
    DV_DONE
  } dv_state_t;

  dv_state_t            state_r, state_nxt;
  logic [TOTAL_W-1:0]   high_r, high_nxt;
  logic [TOTAL_W-1:0]   den_r, den_nxt;
  logic [TOTAL_W-1:0]   rem_r, rem_nxt;
  logic [DUTY_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  logic [NUM_W-1:0]     product;
  logic [TOTAL_W:0]     trial;
  logic                 fits;

  assign product = NUM_W'(high_r) * NUM_W'(DUTY_SCALE);
  assign trial   = {rem_r, quo_r[DUTY_W-1]};
  assign fits    = trial >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    high_nxt  = high_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    case (state_r)
      DV_MUL: begin
        // quotient is below 2^DUTY_W, so the upper part is already below den
        rem_nxt   = product[NUM_W-1:DUTY_W];
        quo_nxt   = product[DUTY_W-1:0];
        step_nxt  = '0;
        state_nxt = DV_STEP;
      end
      DV_STEP: begin
        rem_nxt  = fits ? TOTAL_W'(trial - {1'b0, den_r}) : trial[TOTAL_W-1:0];
        quo_nxt  = {quo_r[DUTY_W-2:0], fits};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DUTY_W - 1)) begin
          state_nxt = DV_DONE;
        end
      end
      default: ;
    endcase
    if (req.start) begin
      high_nxt  = req.high;
      den_nxt   = req.total;
      state_nxt = DV_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    high_r <= high_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign rsp.done     = state_r == DV_DONE;
  assign rsp.quotient = (den_r == '0) ? '0 : quo_r;

endmodule
